[sv/aue_pkg.sv]
// ----------------------------------------------------------------------------
// aue_pkg: shared constants and types of the Adam update engine
// Widths, reset values, register indexes and the sideband carried through
// the root and divide pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

package aue_pkg;

	// moment store geometry
	localparam int DEPTH   = 4096;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int EPOCH_W = 8;

	// field widths
	localparam int IDX_W    = 12;
	localparam int VAL_W    = 32;
	localparam int BETA_W   = 16;
	localparam int STAB_W   = 24;
	localparam int RATE_W   = 24;
	localparam int PERIOD_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BETA_SECOND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABILIZER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_PERIOD = 3'd3;

	// reset values
	localparam logic [BETA_W-1:0] BETA_FIRST_RST  = 16'd58982;
	localparam logic [BETA_W-1:0] BETA_SECOND_RST = 16'd65470;
	localparam logic [STAB_W-1:0] STAB_RST        = 24'd1;
	localparam logic [31:0]       ONE_Q31         = 32'h8000_0000;

	// iteration counts of the root and divide pipelines
	localparam int SQ_STAGES  = 32;
	localparam int DIV_STAGES = 64;

	// per-element values that ride along the arithmetic pipelines
	typedef struct packed {
		logic [31:0]       mmag;
		logic              m_pos;
		logic [RATE_W-1:0] lr;
		logic [31:0]       c1;
		logic              last;
	} aue_side_t;

endpackage

`default_nettype wire

[sv/aue_if.sv]
// ----------------------------------------------------------------------------
// aue_if: stream channels of the Adam update engine
// Gradient element channel and update result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface aue_in_if;
	logic              valid;
	logic              ready;
	logic [11:0]       element_index;
	logic signed [31:0] gradient;
	logic [23:0]       step_rate;
	logic              pass_end;

	modport source(output valid, element_index, gradient, step_rate, pass_end, input ready);
	modport sink(input valid, element_index, gradient, step_rate, pass_end, output ready);
endinterface

interface aue_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] update_value;
	logic               update_last;

	modport source(output valid, update_value, update_last, input ready);
	modport sink(input valid, update_value, update_last, output ready);
endinterface

`default_nettype wire

[sv/aue_moment.sv]
// ----------------------------------------------------------------------------
// aue_moment: moment store with read-modify-write
// Holds both moments with an epoch tag per entry; updates them one element per
// cycle unless stalled, forwards back-to-back hits and sweeps tags on wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module aue_moment (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        adv,
	input  wire logic                        acc,
	input  wire logic [aue_pkg::IDX_W-1:0]   idx,
	input  wire logic signed [31:0]          grad,
	input  wire logic                        clr,
	input  wire logic [aue_pkg::BETA_W-1:0]  beta1,
	input  wire logic [aue_pkg::BETA_W-1:0]  beta2,
	output      logic                        busy,
	output      logic signed [31:0]          m_out,
	output      logic [31:0]                 v_out
);

	localparam int AW  = aue_pkg::AW;
	localparam int EW  = aue_pkg::EPOCH_W;
	localparam int MW  = 64 + EW;
	localparam int GSW = 39;

	logic [MW-1:0] mem [aue_pkg::DEPTH];
	logic [MW-1:0] rd_q;

	// stage 1
	logic                val_s1;
	logic                inr_s1;
	logic [AW-1:0]       addr_s1;
	logic [EW-1:0]       ep_s1;
	logic signed [31:0]  g_s1;
	logic [GSW-1:0]      gsq_s1;

	// stage 2 (also the forwarding source)
	logic                fw_ok_s2;
	logic [AW-1:0]       addr_s2;
	logic [EW-1:0]       ep_s2;
	logic signed [31:0]  m_s2;
	logic [31:0]         v_s2;

	logic [EW-1:0] epoch_q;
	logic          swp_q;
	logic [AW-1:0] swp_cnt_q;

	logic [31:0]        g_u, gmag;
	logic [63:0]        gsq_full;
	logic               hit, old_ok;
	logic signed [31:0] m_old;
	logic [31:0]        v_old;
	logic signed [16:0] b1s;
	logic signed [17:0] b1c;
	logic [16:0]        b2c;
	logic signed [50:0] msum;
	logic [55:0]        vsum;
	logic [39:0]        vsh;
	logic signed [31:0] m_new;
	logic [31:0]        v_new;
	logic               we_pipe, we_sweep;
	logic               inr_in;

	// square the gradient magnitude on the way in
	always_comb begin
		g_u      = grad;
		gmag     = grad[31] ? (~g_u + 32'd1) : g_u;
		gsq_full = 64'(gmag) * 64'(gmag);
		inr_in   = 32'(idx) < 32'(aue_pkg::DEPTH);
	end

	// read the entry at accept
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= mem[AW'(idx)];
		end
	end

	// pick old moments: forwarded, stored, or zero when the tag is stale
	always_comb begin
		hit = fw_ok_s2 && (addr_s2 == addr_s1);
		if (hit) begin
			old_ok = (ep_s2 == ep_s1);
			m_old  = m_s2;
			v_old  = v_s2;
		end else begin
			old_ok = (rd_q[MW-1 -: EW] == ep_s1);
			m_old  = signed'(rd_q[63:32]);
			v_old  = rd_q[31:0];
		end
		if (!(inr_s1 && old_ok)) begin
			m_old = '0;
			v_old = '0;
		end
	end

	// moment update
	always_comb begin
		b1s   = signed'({1'b0, beta1});
		b1c   = signed'({1'b0, 17'(17'd65536 - {1'b0, beta1})});
		b2c   = 17'(17'd65536 - {1'b0, beta2});
		msum  = 51'(b1s) * 51'(m_old) + 51'(b1c) * 51'(g_s1);
		m_new = signed'(msum[47:16]);
		vsum  = 56'(beta2) * 56'(v_old) + 56'(b2c) * 56'(gsq_s1);
		vsh   = vsum[55:16];
		v_new = (|vsh[39:32]) ? 32'hFFFF_FFFF : vsh[31:0];
	end

	assign we_pipe  = adv && val_s1 && inr_s1;
	assign we_sweep = swp_q && !val_s1;

	// write back, else advance the tag sweep
	always_ff @(posedge clk) begin
		if (we_pipe) begin
			mem[addr_s1] <= {ep_s1, m_new, v_new};
		end else if (we_sweep) begin
			mem[swp_cnt_q] <= '0;
		end
	end

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1   <= 1'b0;
			fw_ok_s2 <= 1'b0;
		end else if (adv) begin
			val_s1   <= acc;
			fw_ok_s2 <= val_s1 && inr_s1;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s1  <= inr_in;
			addr_s1 <= AW'(idx);
			ep_s1   <= epoch_q;
			g_s1    <= grad;
			gsq_s1  <= GSW'(gsq_full >> 24);
			addr_s2 <= addr_s1;
			ep_s2   <= ep_s1;
			m_s2    <= m_new;
			v_s2    <= v_new;
		end
	end

	// epoch advance on a clear; sweep tags after reset and on epoch wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= EW'(1);
			swp_q     <= 1'b1;
			swp_cnt_q <= '0;
		end else begin
			if (we_sweep) begin
				if (swp_cnt_q == AW'(aue_pkg::DEPTH - 1)) begin
					swp_q     <= 1'b0;
					swp_cnt_q <= '0;
				end else begin
					swp_cnt_q <= swp_cnt_q + AW'(1);
				end
			end
			if (acc && clr) begin
				if (epoch_q == '1) begin
					epoch_q   <= EW'(1);
					swp_q     <= 1'b1;
					swp_cnt_q <= '0;
				end else begin
					epoch_q <= epoch_q + EW'(1);
				end
			end
		end
	end

	assign busy  = swp_q;
	assign m_out = m_s2;
	assign v_out = v_s2;

endmodule

`default_nettype wire

[sv/aue_sqrt.sv]
// ----------------------------------------------------------------------------
// aue_sqrt: two-lane pipelined integer square root
// Floor root of two 64-bit radicands, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module aue_sqrt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_val,
	input  wire logic [63:0]       rad_a,
	input  wire logic [63:0]       rad_b,
	input  wire aue_pkg::aue_side_t side_in,
	output      logic              out_val,
	output      logic [31:0]       root_a,
	output      logic [31:0]       root_b,
	output      aue_pkg::aue_side_t side_out
);

	localparam int N = aue_pkg::SQ_STAGES;

	logic [N:0]          val_s;
	logic [63:0]         rad_s  [0:1][0:N];
	logic [35:0]         rem_s  [0:1][0:N];
	logic [31:0]         root_s [0:1][0:N];
	aue_pkg::aue_side_t  side_s [0:N];

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s <= '0;
		end else if (adv) begin
			val_s <= {val_s[N-1:0], in_val};
		end
	end

	// capture operands
	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s[0][0]  <= rad_a;
			rad_s[1][0]  <= rad_b;
			rem_s[0][0]  <= '0;
			rem_s[1][0]  <= '0;
			root_s[0][0] <= '0;
			root_s[1][0] <= '0;
			side_s[0]    <= side_in;
		end
	end

	// one root bit per stage and lane
	for (genvar k = 1; k <= N; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [35:0] cand, trial;
			logic        ge;
			always_comb begin
				cand  = {rem_s[l][k-1][33:0], rad_s[l][k-1][63:62]};
				trial = {2'b00, root_s[l][k-1], 2'b01};
				ge    = (cand >= trial);
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					rad_s[l][k]  <= {rad_s[l][k-1][61:0], 2'b00};
					rem_s[l][k]  <= ge ? (cand - trial) : cand;
					root_s[l][k] <= {root_s[l][k-1][30:0], ge};
				end
			end
		end
	end

	assign out_val  = val_s[N];
	assign root_a   = root_s[0][N];
	assign root_b   = root_s[1][N];
	assign side_out = side_s[N];

endmodule

`default_nettype wire

[sv/aue_div.sv]
// ----------------------------------------------------------------------------
// aue_div: two-lane pipelined restoring divider
// 64-bit by 32-bit unsigned quotient, one quotient bit per stage.
// A zero divisor gives an all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module aue_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_val,
	input  wire logic [63:0]       num_a,
	input  wire logic [31:0]       den_a,
	input  wire logic [63:0]       num_b,
	input  wire logic [31:0]       den_b,
	input  wire aue_pkg::aue_side_t side_in,
	output      logic              out_val,
	output      logic [63:0]       quo_a,
	output      logic [63:0]       quo_b,
	output      aue_pkg::aue_side_t side_out
);

	localparam int N = aue_pkg::DIV_STAGES;

	logic [N:0]          val_s;
	logic [63:0]         nq_s  [0:1][0:N];
	logic [31:0]         rem_s [0:1][0:N];
	logic [31:0]         den_s [0:1][0:N];
	aue_pkg::aue_side_t  side_s [0:N];

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s <= '0;
		end else if (adv) begin
			val_s <= {val_s[N-1:0], in_val};
		end
	end

	// capture operands
	always_ff @(posedge clk) begin
		if (adv) begin
			nq_s[0][0]  <= num_a;
			nq_s[1][0]  <= num_b;
			den_s[0][0] <= den_a;
			den_s[1][0] <= den_b;
			rem_s[0][0] <= '0;
			rem_s[1][0] <= '0;
			side_s[0]   <= side_in;
		end
	end

	// shift the numerator out and the quotient in, one bit per stage
	for (genvar k = 1; k <= N; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [32:0] cand, diff;
			logic        ge;
			always_comb begin
				cand = {rem_s[l][k-1], nq_s[l][k-1][63]};
				diff = cand - {1'b0, den_s[l][k-1]};
				ge   = (cand >= {1'b0, den_s[l][k-1]});
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					nq_s[l][k]  <= {nq_s[l][k-1][62:0], ge};
					rem_s[l][k] <= ge ? diff[31:0] : cand[31:0];
					den_s[l][k] <= den_s[l][k-1];
				end
			end
		end
	end

	assign out_val  = val_s[N];
	assign quo_a    = nq_s[0][N];
	assign quo_b    = nq_s[1][N];
	assign side_out = side_s[N];

endmodule

`default_nettype wire

[sv/adam_update_engine_unit.sv]
// ----------------------------------------------------------------------------
// adam_update_engine_unit: fixed-point Adam update engine
// Updates per-element moments in a tagged memory and streams out
// -scale*m/(sqrt(v)+eps') with pass-level bias correction.
//
//  channel        dir   handshake      payload
//  grad_stream    in    valid/ready    element_index, gradient, step_rate, pass_end
//  update_stream  out   valid/ready    update_value, update_last
//  cfg            in    cfg_wr_en      cfg_index, cfg_data
//
//  One element per cycle when not stalled or sweeping; from accept to the output
//  register each element passes the 32-stage root and 64-stage divide pipelines.
//  After reset a tag sweep over all 4096 entries holds grad_stream.ready low; the
//  same sweep runs again on every 255th moment clear (epoch wrap).
//  The pipeline stalls only when a result reaches a full output register.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_update_engine_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	aue_in_if.sink                                grad_stream,
	aue_out_if.source                             update_stream,
	input  wire logic                             cfg_wr_en,
	input  wire logic [aue_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [aue_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// configuration and pass state
	logic [15:0] beta1_q, beta2_q, period_q, cnt_q;
	logic [23:0] stab_q;
	logic [31:0] pow1_q, pow2_q;

	logic        adv, acc, busy, clr;
	logic [15:0] cnt_nx;
	logic [47:0] p1_full, p2_full;
	logic [31:0] p1, p2;

	// stages 1 and 2
	logic        val_s1, val_s2;
	logic [23:0] lr_s1, lr_s2;
	logic        last_s1, last_s2;
	logic [31:0] p1_s1, p2_s1, c1_s2, omp2_s2;
	logic [31:0] c1_raw;

	logic signed [31:0] m_cur;
	logic [31:0]        v_cur, m_u;
	aue_pkg::aue_side_t side_in2;

	// root pipeline
	logic               sq_val;
	logic [31:0]        sq_a, sq_b;
	aue_pkg::aue_side_t sq_side;

	// stage 36
	logic               val_s36;
	logic [31:0]        s_s36, r_s36;
	logic [23:0]        eps_s36;
	aue_pkg::aue_side_t side_s36;
	logic [55:0]        eps_full, lrs_full;
	logic [31:0]        den_d;

	// divide pipeline
	logic               dv_val;
	logic [63:0]        sc, rq;
	aue_pkg::aue_side_t dv_side;

	// stage 102
	logic        val_s102, hh_s102, zero_s102, mpos_s102, last_s102;
	logic [63:0] pll_s102, plh_s102, phl_s102;

	// output
	logic               out_val_q, last_q;
	logic signed [31:0] res_q;
	logic [65:0]        mid, limit;
	logic               over;
	logic [31:0]        mag, res;

	assign adv = !(val_s102 && out_val_q && !update_stream.ready);
	assign grad_stream.ready = adv && !busy;
	assign acc = grad_stream.valid && grad_stream.ready;

	// next powers and clear decision
	always_comb begin
		p1_full = 48'(pow1_q) * 48'(beta1_q);
		p2_full = 48'(pow2_q) * 48'(beta2_q);
		p1      = p1_full[47:16];
		p2      = p2_full[47:16];
		cnt_nx  = cnt_q + 16'd1;
		clr     = grad_stream.pass_end && (period_q != 16'd0) && (cnt_nx == period_q);
	end

	// config writes and pass bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta1_q  <= aue_pkg::BETA_FIRST_RST;
			beta2_q  <= aue_pkg::BETA_SECOND_RST;
			stab_q   <= aue_pkg::STAB_RST;
			period_q <= '0;
			cnt_q    <= '0;
			pow1_q   <= aue_pkg::ONE_Q31;
			pow2_q   <= aue_pkg::ONE_Q31;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					aue_pkg::CFG_BETA_FIRST:   beta1_q  <= cfg_data[15:0];
					aue_pkg::CFG_BETA_SECOND:  beta2_q  <= cfg_data[15:0];
					aue_pkg::CFG_STABILIZER:   stab_q   <= cfg_data[23:0];
					aue_pkg::CFG_RESET_PERIOD: period_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (acc && grad_stream.pass_end) begin
				if (clr) begin
					cnt_q  <= '0;
					pow1_q <= aue_pkg::ONE_Q31;
					pow2_q <= aue_pkg::ONE_Q31;
				end else begin
					cnt_q  <= cnt_nx;
					pow1_q <= p1;
					pow2_q <= p2;
				end
			end
		end
	end

	aue_moment u_moment (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.acc    (acc),
		.idx    (grad_stream.element_index),
		.grad   (grad_stream.gradient),
		.clr    (clr),
		.beta1  (beta1_q),
		.beta2  (beta2_q),
		.busy   (busy),
		.m_out  (m_cur),
		.v_out  (v_cur)
	);

	// stage 1 and 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
		end else if (adv) begin
			val_s1 <= acc;
			val_s2 <= val_s1;
		end
	end

	assign c1_raw = aue_pkg::ONE_Q31 - p1_s1;

	// stage 1 and 2 payload
	always_ff @(posedge clk) begin
		if (adv) begin
			lr_s1   <= grad_stream.step_rate;
			last_s1 <= grad_stream.pass_end;
			p1_s1   <= p1;
			p2_s1   <= p2;
			lr_s2   <= lr_s1;
			last_s2 <= last_s1;
			c1_s2   <= (c1_raw == 32'd0) ? 32'd1 : c1_raw;
			omp2_s2 <= aue_pkg::ONE_Q31 - p2_s1;
		end
	end

	// sideband for the arithmetic pipelines
	always_comb begin
		m_u            = m_cur;
		side_in2.mmag  = m_cur[31] ? (~m_u + 32'd1) : m_u;
		side_in2.m_pos = !m_cur[31] && (m_u != 32'd0);
		side_in2.lr    = lr_s2;
		side_in2.c1    = c1_s2;
		side_in2.last  = last_s2;
	end

	aue_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_val   (val_s2),
		.rad_a    ({1'b0, omp2_s2, 31'd0}),
		.rad_b    ({8'd0, v_cur, 24'd0}),
		.side_in  (side_in2),
		.out_val  (sq_val),
		.root_a   (sq_a),
		.root_b   (sq_b),
		.side_out (sq_side)
	);

	// scaled epsilon
	assign eps_full = 56'(stab_q) * 56'(sq_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s36 <= 1'b0;
		end else if (adv) begin
			val_s36 <= sq_val;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s36    <= sq_a;
			r_s36    <= sq_b;
			eps_s36  <= eps_full[54:31];
			side_s36 <= sq_side;
		end
	end

	// divider operands: scale numerator and denominator root plus epsilon
	always_comb begin
		lrs_full = 56'(side_s36.lr) * 56'(s_s36);
		den_d    = r_s36 + 32'(eps_s36);
	end

	aue_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_val   (val_s36),
		.num_a    ({lrs_full, 8'd0}),
		.den_a    (side_s36.c1),
		.num_b    ({8'd0, side_s36.mmag, 24'd0}),
		.den_b    (den_d),
		.side_in  (side_s36),
		.out_val  (dv_val),
		.quo_a    (sc),
		.quo_b    (rq),
		.side_out (dv_side)
	);

	// partial products of scale times ratio
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s102 <= 1'b0;
		end else if (adv) begin
			val_s102 <= dv_val;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s102  <= 64'(sc[31:0]) * 64'(rq[31:0]);
			plh_s102  <= 64'(sc[31:0]) * 64'(rq[63:32]);
			phl_s102  <= 64'(sc[63:32]) * 64'(rq[31:0]);
			hh_s102   <= (|sc[63:32]) && (|rq[63:32]);
			zero_s102 <= (dv_side.mmag == 32'd0);
			mpos_s102 <= dv_side.m_pos;
			last_s102 <= dv_side.last;
		end
	end

	// sum, saturate and apply the sign
	always_comb begin
		mid   = 66'(plh_s102) + 66'(phl_s102) + 66'(pll_s102[63:32]);
		limit = mpos_s102 ? 66'h0_8000_0000 : 66'h0_7FFF_FFFF;
		over  = hh_s102 || (mid > limit);
		mag   = over ? limit[31:0] : mid[31:0];
		if (zero_s102) begin
			res = '0;
		end else begin
			res = mpos_s102 ? (~mag + 32'd1) : mag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_val_q <= 1'b0;
		end else if (val_s102 && adv) begin
			out_val_q <= 1'b1;
		end else if (update_stream.ready) begin
			out_val_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (val_s102 && adv) begin
			res_q  <= signed'(res);
			last_q <= last_s102;
		end
	end

	assign update_stream.valid        = out_val_q;
	assign update_stream.update_value = res_q;
	assign update_stream.update_last  = last_q;

endmodule

`default_nettype wire

[tb/adam_update_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// adam_update_engine_unit_tb: self-checking bench of the Adam update engine
// Drives gradient transactions with random gaps and result back-pressure,
// computes each expected update with a bit-exact fixed-point Adam model kept
// in a small scoreboard class, and compares every result in order. Covers
// the field extremes, zero denominators, moment clears and the epoch wrap of
// the clear tags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_update_engine_unit_tb;

	localparam logic [aue_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
	localparam int DRAIN_CYCLES = 120;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} update_t;

	// Fixed-point Adam state, expected updates and mismatch bookkeeping
	class adam_scoreboard;
		logic [31:0]  mom1 [aue_pkg::DEPTH];
		logic [31:0]  mom2 [aue_pkg::DEPTH];
		bit           tag [aue_pkg::DEPTH];
		bit [15:0]    b1, b2, period, pass_cnt;
		bit [23:0]    stab;
		bit [63:0]    pow1, pow2;
		update_t      pending_updates[$];
		int           failures;

		function new();
			b1 = aue_pkg::BETA_FIRST_RST;
			b2 = aue_pkg::BETA_SECOND_RST;
			stab = aue_pkg::STAB_RST;
			period = 0;
			pass_cnt = 0;
			pow1 = aue_pkg::ONE_Q31;
			pow2 = aue_pkg::ONE_Q31;
			failures = 0;
			foreach (tag[i]) tag[i] = 0;
		endfunction

		function void set_reg(logic [aue_pkg::CFG_IDX_W-1:0] index,
				logic [aue_pkg::CFG_DATA_W-1:0] data);
			case (index)
				aue_pkg::CFG_BETA_FIRST: b1 = data[15:0];
				aue_pkg::CFG_BETA_SECOND: b2 = data[15:0];
				aue_pkg::CFG_STABILIZER: stab = data;
				aue_pkg::CFG_RESET_PERIOD: period = data[15:0];
				default: ;
			endcase
		endfunction

		function automatic bit [63:0] int_sqrt(bit [63:0] x);
			bit [63:0] r, b;
			r = 0;
			b = 64'h1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Update the moments of one element and queue the expected parameter change
		function void note_gradient(logic [11:0] idx, logic [31:0] graw, logic [23:0] lr,
				logic last);
			longint g, m_old, m, b1l, b2l;
			bit [63:0] v_old, v, gmag, p1, p2, c1, s, sc, epsp, d, mmag, r, mag, limit;
			bit sat;
			update_t u;
			g = longint'(signed'(graw));
			b1l = b1;
			b2l = b2;
			m_old = 0;
			v_old = 0;
			sat = 0;
			if (tag[idx]) begin
				m_old = longint'(signed'(mom1[idx]));
				v_old = mom2[idx];
			end
			m = (b1l * m_old + (65536 - b1l) * g) >>> 16;
			gmag = (g < 0) ? -g : g;
			v = (b2 * v_old + (65536 - b2l) * ((gmag * gmag) >> 24)) >> 16;
			if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
			mom1[idx] = m[31:0];
			mom2[idx] = v[31:0];
			tag[idx] = 1;

			p1 = (pow1 * b1) >> 16;
			p2 = (pow2 * b2) >> 16;
			c1 = aue_pkg::ONE_Q31 - p1;
			if (c1 == 0) c1 = 1;
			s = int_sqrt((aue_pkg::ONE_Q31 - p2) << 31);
			sc = ((lr * s) << 8) / c1;
			epsp = (stab * s) >> 31;
			d = int_sqrt(v << 24) + epsp;
			mmag = (m < 0) ? -m : m;
			if (mmag == 0) r = 0;
			else if (d == 0) r = '1;
			else r = (mmag << 24) / d;
			limit = (m > 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
			if (r != 0 && sc > 64'hFFFF_FFFF_FFFF_FFFF / r) sat = 1;
			if (!sat) begin
				mag = (sc * r) >> 32;
				if (mag > limit) sat = 1;
			end
			if (sat) mag = limit;
			u.value = (m > 0) ? (32'd0 - mag[31:0]) : mag[31:0];
			u.last = last;
			pending_updates.push_back(u);

			// advance the pass and clear the moments on the period
			if (last) begin
				pass_cnt++;
				pow1 = p1;
				pow2 = p2;
				if (period != 0 && pass_cnt == period) begin
					foreach (tag[i]) tag[i] = 0;
					pass_cnt = 0;
					pow1 = aue_pkg::ONE_Q31;
					pow2 = aue_pkg::ONE_Q31;
				end
			end
		endfunction

		function void check_update(logic [31:0] value, logic last);
			update_t exp_u;
			if (pending_updates.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected update: value %h last %b", value, last);
				return;
			end
			exp_u = pending_updates.pop_front();
			if (exp_u.value !== value || exp_u.last !== last) begin
				failures++;
				if (failures <= 10)
					$display("update mismatch: expected %h/%b actual %h/%b",
						exp_u.value, exp_u.last, value, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [aue_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [aue_pkg::CFG_DATA_W-1:0] cfg_data;
	bit no_idle;

	aue_in_if grad_if();
	aue_out_if upd_if();
	adam_scoreboard sb;

	adam_update_engine_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.grad_stream(grad_if.sink),
		.update_stream(upd_if.source),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	// Write one register, holding the write strobe until the next falling edge
	task automatic write_reg(logic [aue_pkg::CFG_IDX_W-1:0] index,
			logic [aue_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en = 1;
		cfg_index = index;
		cfg_data = data;
		sb.set_reg(index, data);
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	task automatic write_all(bit [15:0] b1, bit [15:0] b2, bit [23:0] stab, bit [15:0] per);
		write_reg(aue_pkg::CFG_BETA_FIRST, 24'(b1));
		write_reg(aue_pkg::CFG_BETA_SECOND, 24'(b2));
		write_reg(aue_pkg::CFG_STABILIZER, stab);
		write_reg(aue_pkg::CFG_RESET_PERIOD, 24'(per));
	endtask

	// Hold one gradient transaction until accepted; valid stays high for the caller
	task automatic send_gradient(logic [11:0] idx, logic [31:0] g, logic [23:0] lr,
			logic last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			grad_if.valid = 0;
			repeat (gap) @(negedge clk);
		end
		grad_if.valid = 1;
		grad_if.element_index = idx;
		grad_if.gradient = g;
		grad_if.step_rate = lr;
		grad_if.pass_end = last;
		@(posedge clk);
		while (!grad_if.ready) @(posedge clk);
		sb.note_gradient(idx, g, lr, last);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected update is back and the pipe is empty
	task automatic settle();
		grad_if.valid = 0;
		while (sb.pending_updates.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_gradient();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'(signed'($urandom_range(0, 1 << 25)) - (1 << 24));
			2: return 32'(signed'($urandom_range(0, 4096)) - 2048);
			default: return 32'(signed'($urandom_range(0, 1 << 29)) - (1 << 28));
		endcase
	endfunction

	function automatic logic [23:0] rand_rate();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFF_FFFF;
			default: return 24'($urandom());
		endcase
	endfunction

	// Mostly whole passes over a small vector, some loose elements in between
	task automatic random_items(int count);
		int sent, len;
		logic [23:0] lr;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
			if ($urandom_range(0, 5) == 0) begin
				send_gradient(12'($urandom()), rand_gradient(), rand_rate(),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				len = $urandom_range(1, 16);
				lr = rand_rate();
				for (int i = 0; i < len; i++)
					send_gradient(i[11:0], rand_gradient(), lr, i == len - 1);
				sent += len;
			end
		end
		no_idle = 0;
	endtask

	// Return accepted results with random back-pressure and check them
	initial begin
		int stall;
		upd_if.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = draw_gap();
			if (stall > 0) begin
				upd_if.ready = 0;
				repeat (stall) @(negedge clk);
			end
			upd_if.ready = 1;
			@(posedge clk);
			while (!upd_if.valid) @(posedge clk);
			sb.check_update(upd_if.update_value, upd_if.update_last);
		end
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		sb = new();
		no_idle = 0;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_data = '0;
		grad_if.valid = 0;
		grad_if.element_index = '0;
		grad_if.gradient = '0;
		grad_if.step_rate = '0;
		grad_if.pass_end = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// field extremes under the reset settings
		send_gradient(12'd0, 32'h7FFF_FFFF, 24'hFF_FFFF, 0);
		send_gradient(12'hFFF, 32'h8000_0000, 24'hFF_FFFF, 0);
		send_gradient(12'd0, 32'h7FFF_FFFF, 24'hFF_FFFF, 0);
		send_gradient(12'd1, 32'd0, 24'h80_0000, 0);
		send_gradient(12'd2, 32'h0100_0000, 24'd0, 0);
		send_gradient(12'd3, 32'hFFFF_FFFF, 24'd1, 0);
		send_gradient(12'd4, 32'd1, 24'hFF_FFFF, 0);
		send_gradient(12'hFFF, 32'h8000_0000, 24'hFF_FFFF, 1);
		send_gradient(12'd0, 32'hFF00_0000, 24'h00_1000, 1);
		settle();

		// zero denominator: no epsilon, no memory of the first moment
		write_all(16'd0, 16'd0, 24'd0, 16'd0);
		write_reg(CFG_UNUSED, 24'hFF_FFFF);
		send_gradient(12'd7, 32'd1, 24'hFF_FFFF, 0);
		send_gradient(12'd8, 32'd0, 24'hFF_FFFF, 0);
		send_gradient(12'd9, 32'hFFFF_FFFF, 24'hFF_FFFF, 0);
		send_gradient(12'd10, 32'd0, 24'd0, 1);
		settle();

		// slowest decay, largest epsilon, short period
		write_all(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 16'd1);
		send_gradient(12'd5, 32'h7FFF_FFFF, 24'hFF_FFFF, 1);
		send_gradient(12'd5, 32'h8000_0000, 24'hFF_FFFF, 1);
		settle();

		// random phases over several settings
		write_all(aue_pkg::BETA_FIRST_RST, aue_pkg::BETA_SECOND_RST, aue_pkg::STAB_RST, 16'd0);
		random_items(140);
		settle();
		write_all(16'd0, 16'd0, 24'd0, 16'd1);
		random_items(140);
		settle();
		write_all(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 16'hFFFF);
		random_items(140);
		settle();
		write_all(16'($urandom()), 16'($urandom()), 24'($urandom_range(0, 1 << 16)), 16'd4);
		random_items(140);
		settle();
		write_all(16'($urandom()), 16'($urandom()), 24'($urandom()),
			16'($urandom_range(2, 8)));
		random_items(140);
		settle();
		write_all(aue_pkg::BETA_FIRST_RST, aue_pkg::BETA_SECOND_RST, 24'd1000, 16'd0);
		random_items(140);
		settle();

		// clear on every pass, past the tag epoch wrap
		write_reg(aue_pkg::CFG_RESET_PERIOD, 24'd1);
		no_idle = 1;
		for (int i = 0; i < 300; i++)
			send_gradient(12'($urandom_range(0, 3)), rand_gradient(), rand_rate(), 1);
		no_idle = 0;
		settle();

		if (sb.failures == 0 && sb.pending_updates.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
